// ===== rtl/hbsr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hbsr_pkg
// Shared types, codes and constants of the hall BLDC start/run controller.
// ----------------------------------------------------------------------------
package hbsr_pkg;

    localparam int C_DUTY_W    = 11;
    localparam int C_CUR_W     = 12;
    localparam int C_TICK_W    = 16;
    localparam int C_SPEED_W   = 14;
    localparam int C_CMD_W     = 2;
    localparam int C_HALL_W    = 3;
    localparam int C_STEP_W    = 3;
    localparam int C_MODE_W    = 3;
    localparam int C_KIND_W    = 2;
    localparam int C_FAULT_W   = 2;
    localparam int C_CFG_IDX_W = 3;
    localparam int C_CFG_DAT_W = 16;

    localparam logic [C_SPEED_W-1:0] C_SPEED_TIMEOUT    = C_SPEED_W'(16000);
    localparam logic [C_DUTY_W-1:0]  C_PRECHARGE_DUTY   = C_DUTY_W'(1000);
    localparam logic [1:0]           C_START_EDGES_NEED = 2'd3;
    localparam logic [1:0]           C_COUNT_SAT        = 2'd3;

    // Configuration reset values
    localparam logic [C_DUTY_W-1:0] C_RST_START_MIN  = C_DUTY_W'(200);
    localparam logic [C_DUTY_W-1:0] C_RST_START_STEP = C_DUTY_W'(100);
    localparam logic [C_DUTY_W-1:0] C_RST_START_MAX  = C_DUTY_W'(1000);
    localparam logic [C_CUR_W-1:0]  C_RST_STALL_CUR  = C_CUR_W'(136);
    localparam logic [C_TICK_W-1:0] C_RST_PRECHARGE  = C_TICK_W'(1600);
    localparam logic [C_TICK_W-1:0] C_RST_CUR_LOCK   = C_TICK_W'(1600);
    localparam logic [C_TICK_W-1:0] C_RST_PHASE_LOCK = C_TICK_W'(2400);
    localparam logic [C_TICK_W-1:0] C_RST_STEP_TICKS = C_TICK_W'(4800);

    // Register indexes
    localparam logic [C_CFG_IDX_W-1:0] REG_START_MIN  = 3'd0;
    localparam logic [C_CFG_IDX_W-1:0] REG_START_STEP = 3'd1;
    localparam logic [C_CFG_IDX_W-1:0] REG_START_MAX  = 3'd2;
    localparam logic [C_CFG_IDX_W-1:0] REG_STALL_CUR  = 3'd3;
    localparam logic [C_CFG_IDX_W-1:0] REG_PRECHARGE  = 3'd4;
    localparam logic [C_CFG_IDX_W-1:0] REG_CUR_LOCK   = 3'd5;
    localparam logic [C_CFG_IDX_W-1:0] REG_PHASE_LOCK = 3'd6;
    localparam logic [C_CFG_IDX_W-1:0] REG_STEP_TICKS = 3'd7;

    // Command codes
    localparam logic [C_CMD_W-1:0] CMD_STOP  = 2'd1;
    localparam logic [C_CMD_W-1:0] CMD_START = 2'd2;

    // Drive kinds
    localparam logic [C_KIND_W-1:0] KIND_OFF       = 2'd0;
    localparam logic [C_KIND_W-1:0] KIND_PRECHARGE = 2'd1;
    localparam logic [C_KIND_W-1:0] KIND_COMMUTATE = 2'd2;

    // Fault codes
    localparam logic [C_FAULT_W-1:0] FAULT_NONE      = 2'd0;
    localparam logic [C_FAULT_W-1:0] FAULT_LOCK_CUR  = 2'd1;
    localparam logic [C_FAULT_W-1:0] FAULT_LOCK_PH   = 2'd2;
    localparam logic [C_FAULT_W-1:0] FAULT_START     = 2'd3;

    localparam logic [C_STEP_W-1:0] STEP_OFF = 3'd0;

    typedef enum logic [C_MODE_W-1:0] {
        MODE_STOP      = 3'd0,
        MODE_PRE_READY = 3'd1,
        MODE_PRE_WAIT  = 3'd2,
        MODE_STARTING  = 3'd3,
        MODE_RUNNING   = 3'd4
    } t_mode;

    typedef struct packed {
        logic [C_DUTY_W-1:0] ramp_lo_duty;
        logic [C_DUTY_W-1:0] ramp_inc_duty;
        logic [C_DUTY_W-1:0] ramp_hi_duty;
        logic [C_CUR_W-1:0]  stall_current_limit;
        logic [C_TICK_W-1:0] precharge_ticks;
        logic [C_TICK_W-1:0] current_lock_ticks;
        logic [C_TICK_W-1:0] phase_lock_ticks;
        logic [C_TICK_W-1:0] start_step_ticks;
    } t_cfg;

    typedef struct packed {
        logic [C_CMD_W-1:0]  command;
        logic [C_HALL_W-1:0] hall;
        logic                direction;
        logic [C_DUTY_W-1:0] aim_duty;
        logic [C_CUR_W-1:0]  current_sample;
        logic                commutation_event;
    } t_item;

    typedef struct packed {
        logic [C_MODE_W-1:0]  mode;
        logic [C_KIND_W-1:0]  drive_kind;
        logic [C_STEP_W-1:0]  commutation_step;
        logic [C_DUTY_W-1:0]  duty_out;
        logic [C_FAULT_W-1:0] fault;
        logic                 speed_lost;
    } t_result;

    localparam logic [C_STEP_W-1:0] C_MAP_CW [8] =
        '{3'd0, 3'd2, 3'd4, 3'd3, 3'd6, 3'd1, 3'd5, 3'd0};
    localparam logic [C_STEP_W-1:0] C_MAP_CCW [8] =
        '{3'd0, 3'd5, 3'd1, 3'd6, 3'd3, 3'd4, 3'd2, 3'd0};

    function automatic logic [C_STEP_W-1:0] hall_step(
        input logic [C_HALL_W-1:0] hall,
        input logic                dir
    );
        hall_step = dir ? C_MAP_CCW[hall] : C_MAP_CW[hall];
    endfunction

    function automatic logic [C_FAULT_W-1:0] raise_fault(
        input logic [C_FAULT_W-1:0] cur,
        input logic [C_FAULT_W-1:0] code
    );
        raise_fault = (cur == FAULT_NONE || cur > code) ? code : cur;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/hbsr_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hbsr_if
// Request, result and register write channels of the controller.
// ----------------------------------------------------------------------------
interface hbsr_in_if import hbsr_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [C_CMD_W-1:0]  command;
    logic [C_HALL_W-1:0] hall;
    logic                direction;
    logic [C_DUTY_W-1:0] aim_duty;
    logic [C_CUR_W-1:0]  current_sample;
    logic                commutation_event;

    modport source (output valid, command, hall, direction, aim_duty,
                    current_sample, commutation_event, input ready);
    modport sink (input valid, command, hall, direction, aim_duty,
                  current_sample, commutation_event, output ready);
endinterface

interface hbsr_out_if import hbsr_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [C_MODE_W-1:0]  mode;
    logic [C_KIND_W-1:0]  drive_kind;
    logic [C_STEP_W-1:0]  commutation_step;
    logic [C_DUTY_W-1:0]  duty_out;
    logic [C_FAULT_W-1:0] fault;
    logic                 speed_lost;

    modport source (output valid, mode, drive_kind, commutation_step, duty_out,
                    fault, speed_lost, input ready);
    modport sink (input valid, mode, drive_kind, commutation_step, duty_out,
                  fault, speed_lost, output ready);
endinterface

interface hbsr_cfg_if import hbsr_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [C_CFG_IDX_W-1:0] index;
    logic [C_CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/hbsr_cfg_regs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hbsr_cfg_regs
// Configuration register bank, written one register per request.
// ----------------------------------------------------------------------------
module hbsr_cfg_regs import hbsr_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_wr,
    input  wire logic [C_CFG_IDX_W-1:0] i_index,
    input  wire logic [C_CFG_DAT_W-1:0] i_data,
    output t_cfg                        o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr) begin
            case (i_index)
                REG_START_MIN:  n_cfg.ramp_lo_duty        = i_data[C_DUTY_W-1:0];
                REG_START_STEP: n_cfg.ramp_inc_duty       = i_data[C_DUTY_W-1:0];
                REG_START_MAX:  n_cfg.ramp_hi_duty        = i_data[C_DUTY_W-1:0];
                REG_STALL_CUR:  n_cfg.stall_current_limit = i_data[C_CUR_W-1:0];
                REG_PRECHARGE:  n_cfg.precharge_ticks     = i_data[C_TICK_W-1:0];
                REG_CUR_LOCK:   n_cfg.current_lock_ticks  = i_data[C_TICK_W-1:0];
                REG_PHASE_LOCK: n_cfg.phase_lock_ticks    = i_data[C_TICK_W-1:0];
                REG_STEP_TICKS: n_cfg.start_step_ticks    = i_data[C_TICK_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ramp_lo_duty        <= C_RST_START_MIN;
            r_cfg.ramp_inc_duty       <= C_RST_START_STEP;
            r_cfg.ramp_hi_duty        <= C_RST_START_MAX;
            r_cfg.stall_current_limit <= C_RST_STALL_CUR;
            r_cfg.precharge_ticks     <= C_RST_PRECHARGE;
            r_cfg.current_lock_ticks  <= C_RST_CUR_LOCK;
            r_cfg.phase_lock_ticks    <= C_RST_PHASE_LOCK;
            r_cfg.start_step_ticks    <= C_RST_STEP_TICKS;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

// ===== rtl/hbsr_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hbsr_core
// Per-tick sequencer: mode machine, start-up ramp, stall and speed timers.
// ----------------------------------------------------------------------------
module hbsr_core import hbsr_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_acc,
    input  wire t_item i_item,
    input  wire t_cfg  i_cfg,
    output t_result    o_res
);

    t_mode                 r_mode, n_mode;
    logic [C_TICK_W-1:0]   r_tick_cd, n_tick_cd;
    logic                  r_first, n_first;
    logic [1:0]            r_edges, n_edges;
    logic [C_TICK_W-1:0]   r_nsw, n_nsw;
    logic [C_DUTY_W-1:0]   r_duty, n_duty;
    logic [1:0]            r_fails, n_fails;
    logic [C_SPEED_W-1:0]  r_speed, n_speed;
    logic [C_TICK_W-1:0]   r_cl, n_cl;
    logic [C_TICK_W-1:0]   r_pl, n_pl;
    logic [C_FAULT_W-1:0]  r_fault, n_fault;
    logic [C_STEP_W-1:0]   r_step, n_step;
    logic [C_DUTY_W:0]     w_sum;
    logic                  w_hall_ok;

    assign w_hall_ok = i_item.hall inside {[3'd1:3'd6]};
    assign w_sum     = {1'b0, r_duty} + {1'b0, i_cfg.ramp_inc_duty};

    // next state
    always_comb begin
        n_mode    = r_mode;
        n_tick_cd = r_tick_cd;
        n_first   = r_first;
        n_edges   = r_edges;
        n_nsw     = r_nsw;
        n_duty    = r_duty;
        n_fails   = r_fails;
        n_speed   = r_speed;
        n_cl      = r_cl;
        n_pl      = r_pl;
        n_fault   = r_fault;
        n_step    = r_step;

        if (r_tick_cd != '0) begin
            n_tick_cd = r_tick_cd - C_TICK_W'(1);
        end

        if (i_item.commutation_event) begin
            n_speed = C_SPEED_TIMEOUT;
            n_cl    = i_cfg.current_lock_ticks;
            n_pl    = i_cfg.phase_lock_ticks;
            if (r_mode == MODE_STARTING && r_edges < C_COUNT_SAT) begin
                n_edges = r_edges + 2'd1;
            end
        end

        case (r_mode)
            MODE_PRE_READY: begin
                n_tick_cd = i_cfg.precharge_ticks;
                n_step    = STEP_OFF;
                n_mode    = MODE_PRE_WAIT;
            end
            MODE_PRE_WAIT: begin
                if (n_tick_cd == '0) begin
                    n_step  = STEP_OFF;
                    n_duty  = i_cfg.ramp_lo_duty;
                    n_first = 1'b0;
                    n_edges = 2'd0;
                    n_nsw   = '0;
                    n_mode  = MODE_STARTING;
                end
            end
            MODE_STARTING: begin
                if (!r_first) begin
                    if (w_hall_ok) begin
                        n_step  = hall_step(i_item.hall, i_item.direction);
                        n_first = 1'b1;
                    end
                end else if (n_edges >= C_START_EDGES_NEED) begin
                    n_mode  = MODE_RUNNING;
                    n_edges = 2'd0;
                    n_nsw   = '0;
                    n_first = 1'b0;
                end else begin
                    n_nsw = r_nsw + C_TICK_W'(1);
                    if (n_nsw >= i_cfg.start_step_ticks) begin
                        n_nsw = '0;
                        if (w_sum >= {1'b0, i_cfg.ramp_hi_duty}) begin
                            if (r_fails < C_COUNT_SAT) begin
                                n_fails = r_fails + 2'd1;
                            end
                            if (n_fails >= C_COUNT_SAT) begin
                                n_fault = raise_fault(r_fault, FAULT_START);
                            end
                            n_duty = i_cfg.ramp_hi_duty;
                        end else begin
                            n_duty = w_sum[C_DUTY_W-1:0];
                        end
                    end
                end
            end
            MODE_RUNNING: begin
                n_duty = i_item.aim_duty;
                if (w_hall_ok) begin
                    n_step = hall_step(i_item.hall, i_item.direction);
                end
                if (n_speed != '0) begin
                    n_speed = n_speed - C_SPEED_W'(1);
                end
                if (n_cl != '0) begin
                    n_cl = n_cl - C_TICK_W'(1);
                end else if (i_item.current_sample >= i_cfg.stall_current_limit) begin
                    n_fault = raise_fault(n_fault, FAULT_LOCK_CUR);
                end
                if (n_pl != '0) begin
                    n_pl = n_pl - C_TICK_W'(1);
                end else begin
                    n_fault = raise_fault(n_fault, FAULT_LOCK_PH);
                end
            end
            default: begin
                n_mode  = MODE_STOP;
                n_step  = STEP_OFF;
                n_first = 1'b0;
                n_edges = 2'd0;
                n_nsw   = '0;
                n_cl    = i_cfg.current_lock_ticks;
                n_pl    = i_cfg.phase_lock_ticks;
            end
        endcase

        if (i_item.command == CMD_STOP) begin
            n_mode  = MODE_STOP;
            n_step  = STEP_OFF;
            n_first = 1'b0;
            n_edges = 2'd0;
            n_nsw   = '0;
            n_cl    = i_cfg.current_lock_ticks;
            n_pl    = i_cfg.phase_lock_ticks;
        end else if (i_item.command == CMD_START && n_mode == MODE_STOP) begin
            n_mode = MODE_PRE_READY;
        end
    end

    // outputs, from the state after the tick
    always_comb begin
        o_res.mode             = n_mode;
        o_res.fault            = n_fault;
        o_res.speed_lost       = (n_speed == '0);
        o_res.drive_kind       = KIND_OFF;
        o_res.commutation_step = STEP_OFF;
        o_res.duty_out         = '0;
        if (n_mode == MODE_PRE_WAIT) begin
            o_res.drive_kind = KIND_PRECHARGE;
            o_res.duty_out   = C_PRECHARGE_DUTY;
        end else if ((n_mode == MODE_STARTING || n_mode == MODE_RUNNING)
                     && n_step != STEP_OFF) begin
            o_res.drive_kind       = KIND_COMMUTATE;
            o_res.commutation_step = n_step;
            o_res.duty_out         = n_duty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_STOP;
            r_tick_cd <= '0;
            r_first   <= 1'b0;
            r_edges   <= 2'd0;
            r_nsw     <= '0;
            r_duty    <= '0;
            r_fails   <= 2'd0;
            r_speed   <= '0;
            r_cl      <= C_RST_CUR_LOCK;
            r_pl      <= C_RST_PHASE_LOCK;
            r_fault   <= FAULT_NONE;
            r_step    <= STEP_OFF;
        end else if (i_acc) begin
            r_mode    <= n_mode;
            r_tick_cd <= n_tick_cd;
            r_first   <= n_first;
            r_edges   <= n_edges;
            r_nsw     <= n_nsw;
            r_duty    <= n_duty;
            r_fails   <= n_fails;
            r_speed   <= n_speed;
            r_cl      <= n_cl;
            r_pl      <= n_pl;
            r_fault   <= n_fault;
            r_step    <= n_step;
        end
    end

`ifndef SYNTHESIS
    a_fault_latched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fault != FAULT_NONE) |=> (r_fault != FAULT_NONE))
        else $error("latched fault cleared");

    a_fails_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fails != 2'd0) |=> (r_fails >= $past(r_fails)))
        else $error("start failure count fell");

    a_pre_ready_one_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_acc && r_mode == MODE_PRE_READY) |=>
        (r_mode == MODE_PRE_WAIT || r_mode == MODE_STOP))
        else $error("precharge ready held past one tick");

    a_speed_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_speed <= C_SPEED_TIMEOUT)
        else $error("speed timer above timeout");

    a_run_needs_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_acc && r_mode == MODE_STOP) |=>
        (r_mode == MODE_STOP || r_mode == MODE_PRE_READY))
        else $error("left stop without passing precharge");
`endif

endmodule
`default_nettype wire

// ===== rtl/hall_bldc_start_run_controller.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hall_bldc_start_run_controller
// Hall-sensor BLDC six-step start/run sequencer, one request per PWM tick.
//
// Channels: i_in carries one PWM tick request (command, hall code, direction,
// aim duty, averaged current, commutation event); o_out returns exactly one
// result per request (mode, drive kind, commutation step, duty, fault,
// speed lost). i_cfg writes one configuration register per request, index
// 0..7, and is always ready; write it only while no request is in flight.
// A result is registered and appears in the cycle after its request is taken.
// Throughput: one request per cycle unless the receiver stalls; the mode
// machine and timers are combinational and the result sits in one register.
// Stall: i_in.ready stays high while the output register is empty or is
// being emptied; a stalled receiver holds the result and blocks new requests.
// Reset: synchronous, active low; motor stopped, no fault, configuration back
// to its defaults, output register empty. No clearing pass is needed.
// ----------------------------------------------------------------------------
module hall_bldc_start_run_controller import hbsr_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    hbsr_in_if.sink   i_in,
    hbsr_out_if.source o_out,
    hbsr_cfg_if.sink  i_cfg
);

    t_cfg    w_cfg;
    t_item   w_item;
    t_result w_res;
    t_result r_res;
    logic    r_out_valid;
    logic    w_acc;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign w_acc       = i_in.valid && i_in.ready;

    assign w_item.command           = i_in.command;
    assign w_item.hall              = i_in.hall;
    assign w_item.direction         = i_in.direction;
    assign w_item.aim_duty          = i_in.aim_duty;
    assign w_item.current_sample    = i_in.current_sample;
    assign w_item.commutation_event = i_in.commutation_event;

    hbsr_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg.valid),
        .i_index (i_cfg.index),
        .i_data  (i_cfg.data),
        .o_cfg   (w_cfg)
    );

    hbsr_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (w_acc),
        .i_item  (w_item),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_acc) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_res <= w_res;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.mode             = r_res.mode;
    assign o_out.drive_kind       = r_res.drive_kind;
    assign o_out.commutation_step = r_res.commutation_step;
    assign o_out.duty_out         = r_res.duty_out;
    assign o_out.fault            = r_res.fault;
    assign o_out.speed_lost       = r_res.speed_lost;

endmodule
`default_nettype wire

// ===== tb/sv/hbsr_tick_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hbsr_tick_checker
// Watches the request, result and register write channels of the hall BLDC
// start/run controller. Keeps its own copy of the registers and of the motor
// sequencer state, works out the status due for every accepted request and
// compares each returned result against the oldest one outstanding.
// ----------------------------------------------------------------------------
module hbsr_tick_checker import hbsr_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    hbsr_in_if        i_in,
    hbsr_out_if       i_out,
    hbsr_cfg_if       i_cfg,
    output int        o_errors,
    output int        o_outstanding
);

    t_cfg                  cfg_m;
    t_mode                 mode_m;
    logic [C_TICK_W-1:0]   countdown_m;
    logic                  first_done_m;
    logic [1:0]            edges_m;
    logic [C_TICK_W-1:0]   no_switch_m;
    logic [C_DUTY_W-1:0]   duty_m;
    logic [1:0]            fails_m;
    logic [C_SPEED_W-1:0]  speed_m;
    logic [C_TICK_W-1:0]   cur_lock_m;
    logic [C_TICK_W-1:0]   ph_lock_m;
    logic [C_FAULT_W-1:0]  fault_m;
    logic [C_STEP_W-1:0]   step_m;

    t_result due_status[$];
    int      errors  = 0;
    int      pending = 0;

    assign o_errors      = errors;
    assign o_outstanding = pending;

    function automatic logic [C_STEP_W-1:0] phase_for_hall(
        input logic [C_HALL_W-1:0] hall,
        input logic                ccw
    );
        logic [C_STEP_W-1:0] s;
        case (hall)
            3'd1: s = ccw ? 3'd5 : 3'd2;
            3'd2: s = ccw ? 3'd1 : 3'd4;
            3'd3: s = ccw ? 3'd6 : 3'd3;
            3'd4: s = ccw ? 3'd3 : 3'd6;
            3'd5: s = ccw ? 3'd4 : 3'd1;
            3'd6: s = ccw ? 3'd2 : 3'd5;
            default: s = STEP_OFF;
        endcase
        return s;
    endfunction

    task automatic stop_motor();
        mode_m       = MODE_STOP;
        step_m       = STEP_OFF;
        first_done_m = 1'b0;
        edges_m      = '0;
        no_switch_m  = '0;
        cur_lock_m   = cfg_m.current_lock_ticks;
        ph_lock_m    = cfg_m.phase_lock_ticks;
    endtask

    // lowest code wins, nothing clears it
    task automatic latch_fault(input logic [C_FAULT_W-1:0] code);
        if (fault_m == FAULT_NONE || fault_m > code) begin
            fault_m = code;
        end
    endtask

    task automatic step_controller(input t_item tk, output t_result r);
        logic [C_DUTY_W:0]   sum;
        logic [C_STEP_W-1:0] s;
        s = phase_for_hall(tk.hall, tk.direction);
        if (countdown_m != '0) begin
            countdown_m = countdown_m - 1'b1;
        end
        if (tk.commutation_event) begin
            speed_m    = C_SPEED_TIMEOUT;
            cur_lock_m = cfg_m.current_lock_ticks;
            ph_lock_m  = cfg_m.phase_lock_ticks;
            if (mode_m == MODE_STARTING && edges_m < C_COUNT_SAT) begin
                edges_m = edges_m + 1'b1;
            end
        end
        case (mode_m)
            MODE_PRE_READY: begin
                countdown_m = cfg_m.precharge_ticks;
                step_m      = STEP_OFF;
                mode_m      = MODE_PRE_WAIT;
            end
            MODE_PRE_WAIT: begin
                if (countdown_m == '0) begin
                    step_m       = STEP_OFF;
                    duty_m       = cfg_m.ramp_lo_duty;
                    first_done_m = 1'b0;
                    edges_m      = '0;
                    no_switch_m  = '0;
                    mode_m       = MODE_STARTING;
                end
            end
            MODE_STARTING: begin
                if (!first_done_m) begin
                    if (s != STEP_OFF) begin
                        step_m       = s;
                        first_done_m = 1'b1;
                    end
                end else if (edges_m >= C_START_EDGES_NEED) begin
                    mode_m       = MODE_RUNNING;
                    edges_m      = '0;
                    no_switch_m  = '0;
                    first_done_m = 1'b0;
                end else begin
                    no_switch_m = no_switch_m + 1'b1;
                    if (no_switch_m >= cfg_m.start_step_ticks) begin
                        no_switch_m = '0;
                        sum = {1'b0, duty_m} + {1'b0, cfg_m.ramp_inc_duty};
                        if (sum >= {1'b0, cfg_m.ramp_hi_duty}) begin
                            if (fails_m < C_COUNT_SAT) begin
                                fails_m = fails_m + 1'b1;
                            end
                            if (fails_m >= C_COUNT_SAT) begin
                                latch_fault(FAULT_START);
                            end
                            sum = {1'b0, cfg_m.ramp_hi_duty};
                        end
                        duty_m = sum[C_DUTY_W-1:0];
                    end
                end
            end
            MODE_RUNNING: begin
                duty_m = tk.aim_duty;
                if (s != STEP_OFF) begin
                    step_m = s;
                end
                if (speed_m != '0) begin
                    speed_m = speed_m - 1'b1;
                end
                if (cur_lock_m != '0) begin
                    cur_lock_m = cur_lock_m - 1'b1;
                end else if (tk.current_sample >= cfg_m.stall_current_limit) begin
                    latch_fault(FAULT_LOCK_CUR);
                end
                if (ph_lock_m != '0) begin
                    ph_lock_m = ph_lock_m - 1'b1;
                end else begin
                    latch_fault(FAULT_LOCK_PH);
                end
            end
            default: begin
                stop_motor();
            end
        endcase

        if (tk.command == CMD_STOP) begin
            stop_motor();
        end else if (tk.command == CMD_START && mode_m == MODE_STOP) begin
            mode_m = MODE_PRE_READY;
        end

        r            = '0;
        r.mode       = mode_m;
        r.fault      = fault_m;
        r.speed_lost = (speed_m == '0);
        if (mode_m == MODE_PRE_WAIT) begin
            r.drive_kind = KIND_PRECHARGE;
            r.duty_out   = C_PRECHARGE_DUTY;
        end else if ((mode_m == MODE_STARTING || mode_m == MODE_RUNNING) &&
                     step_m != STEP_OFF) begin
            r.drive_kind       = KIND_COMMUTATE;
            r.commutation_step = step_m;
            r.duty_out         = duty_m;
        end else begin
            r.drive_kind = KIND_OFF;
        end
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_item   tk;
        t_result want;
        if (!i_rst_n) begin
            cfg_m.ramp_lo_duty        = C_RST_START_MIN;
            cfg_m.ramp_inc_duty       = C_RST_START_STEP;
            cfg_m.ramp_hi_duty        = C_RST_START_MAX;
            cfg_m.stall_current_limit = C_RST_STALL_CUR;
            cfg_m.precharge_ticks     = C_RST_PRECHARGE;
            cfg_m.current_lock_ticks  = C_RST_CUR_LOCK;
            cfg_m.phase_lock_ticks    = C_RST_PHASE_LOCK;
            cfg_m.start_step_ticks    = C_RST_STEP_TICKS;
            countdown_m = '0;
            duty_m      = '0;
            fails_m     = '0;
            speed_m     = '0;
            fault_m     = FAULT_NONE;
            stop_motor();
            due_status.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    REG_START_MIN:  cfg_m.ramp_lo_duty        = i_cfg.data[C_DUTY_W-1:0];
                    REG_START_STEP: cfg_m.ramp_inc_duty       = i_cfg.data[C_DUTY_W-1:0];
                    REG_START_MAX:  cfg_m.ramp_hi_duty        = i_cfg.data[C_DUTY_W-1:0];
                    REG_STALL_CUR:  cfg_m.stall_current_limit = i_cfg.data[C_CUR_W-1:0];
                    REG_PRECHARGE:  cfg_m.precharge_ticks     = i_cfg.data;
                    REG_CUR_LOCK:   cfg_m.current_lock_ticks  = i_cfg.data;
                    REG_PHASE_LOCK: cfg_m.phase_lock_ticks    = i_cfg.data;
                    REG_STEP_TICKS: cfg_m.start_step_ticks    = i_cfg.data;
                    default: ;
                endcase
            end
            // retire before taking the new request: a result always trails its request
            if (i_out.valid && i_out.ready) begin
                if (due_status.size() == 0) begin
                    $error("result returned with no request outstanding");
                    errors++;
                end else begin
                    want = due_status.pop_front();
                    check_field("mode", want.mode, i_out.mode);
                    check_field("drive_kind", want.drive_kind, i_out.drive_kind);
                    check_field("commutation_step", want.commutation_step,
                                i_out.commutation_step);
                    check_field("duty_out", want.duty_out, i_out.duty_out);
                    check_field("fault", want.fault, i_out.fault);
                    check_field("speed_lost", want.speed_lost, i_out.speed_lost);
                end
            end
            if (i_in.valid && i_in.ready) begin
                tk.command           = i_in.command;
                tk.hall              = i_in.hall;
                tk.direction         = i_in.direction;
                tk.aim_duty          = i_in.aim_duty;
                tk.current_sample    = i_in.current_sample;
                tk.commutation_event = i_in.commutation_event;
                step_controller(tk, want);
                due_status.push_back(want);
            end
        end
        pending = due_status.size();
    end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the hall BLDC start/run controller. A short directed walk
// through stop, precharge, start-up and run is followed by random PWM tick
// requests under a series of register settings, including all-zero and
// all-maximum ones, a run without hall edges and phases that provoke
// each fault. Both sides stall in random bursts; the checker does the rest.
// ----------------------------------------------------------------------------
module tb;
    import hbsr_pkg::*;

    localparam logic [C_CMD_W-1:0] CMD_NONE     = 2'd0;
    localparam logic [C_CMD_W-1:0] CMD_RESERVED = 2'd3;
    localparam int                 QUIET_LIMIT  = 1000;

    logic i_clk    = 1'b0;
    logic i_rst_n  = 1'b0;
    logic rx_ready = 1'b0;
    bit   jitter   = 1'b0;
    int   stall_left = 0;
    int   errors;
    int   outstanding;

    hbsr_in_if  in_ch();
    hbsr_out_if out_ch();
    hbsr_cfg_if cfg_ch();

    assign out_ch.ready = rx_ready;

    hall_bldc_start_run_controller uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    hbsr_tick_checker u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (in_ch),
        .i_out         (out_ch),
        .i_cfg         (cfg_ch),
        .o_errors      (errors),
        .o_outstanding (outstanding)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // result side back-pressure
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            rx_ready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (jitter && $urandom_range(0, 11) == 0) begin
            rx_ready   <= 1'b0;
            stall_left <= $urandom_range(0, 12);
        end else begin
            rx_ready <= 1'b1;
        end
    end

    function automatic t_item tick_item(input logic [C_CMD_W-1:0] cmd, input int hall,
                                        input bit dir, input int aim, input int cur,
                                        input bit ev);
        t_item it;
        it.command           = cmd;
        it.hall              = C_HALL_W'(hall);
        it.direction         = dir;
        it.aim_duty          = C_DUTY_W'(aim);
        it.current_sample    = C_CUR_W'(cur);
        it.commutation_event = ev;
        return it;
    endfunction

    function automatic t_item rand_tick(input int stop_pct, input int start_pct,
                                        input int ev_pct, input int cur_hi);
        t_item it;
        int    r;
        r = $urandom_range(0, 99);
        if (r < stop_pct)
            it.command = CMD_STOP;
        else if (r < stop_pct + start_pct)
            it.command = CMD_START;
        else if (r < stop_pct + start_pct + 2)
            it.command = CMD_RESERVED;
        else
            it.command = CMD_NONE;
        if ($urandom_range(0, 9) == 0)
            it.hall = $urandom_range(0, 1) ? 3'd7 : 3'd0;
        else
            it.hall = C_HALL_W'($urandom_range(1, 6));
        it.direction         = 1'($urandom_range(0, 1));
        it.aim_duty          = C_DUTY_W'($urandom_range(0, 2047));
        it.current_sample    = C_CUR_W'($urandom_range(0, cur_hi));
        it.commutation_event = ($urandom_range(0, 99) < ev_pct);
        return it;
    endfunction

    function automatic t_cfg fast_cfg(input int cl_lo, input int cl_hi,
                                      input int pl_lo, input int pl_hi);
        t_cfg c;
        c.ramp_lo_duty        = C_DUTY_W'($urandom_range(0, 1500));
        c.ramp_inc_duty       = C_DUTY_W'($urandom_range(0, 700));
        c.ramp_hi_duty        = C_DUTY_W'($urandom_range(0, 2047));
        c.stall_current_limit = C_CUR_W'($urandom_range(0, 4095));
        c.precharge_ticks     = C_TICK_W'($urandom_range(0, 6));
        c.current_lock_ticks  = C_TICK_W'($urandom_range(cl_lo, cl_hi));
        c.phase_lock_ticks    = C_TICK_W'($urandom_range(pl_lo, pl_hi));
        c.start_step_ticks    = C_TICK_W'($urandom_range(0, 8));
        return c;
    endfunction

    task automatic send_tick(input t_item it);
        if (jitter && $urandom_range(0, 9) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge i_clk);
        end
        in_ch.valid             <= 1'b1;
        in_ch.command           <= it.command;
        in_ch.hall              <= it.hall;
        in_ch.direction         <= it.direction;
        in_ch.aim_duty          <= it.aim_duty;
        in_ch.current_sample    <= it.current_sample;
        in_ch.commutation_event <= it.commutation_event;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
    endtask

    // hold off until every request has its result back
    task automatic drain();
        in_ch.valid <= 1'b0;
        wait (outstanding == 0);
        @(negedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic put_reg(input logic [C_CFG_IDX_W-1:0] idx,
                           input logic [C_CFG_DAT_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic write_config(input t_cfg c);
        drain();
        put_reg(REG_START_MIN,  C_CFG_DAT_W'(c.ramp_lo_duty));
        put_reg(REG_START_STEP, C_CFG_DAT_W'(c.ramp_inc_duty));
        put_reg(REG_START_MAX,  C_CFG_DAT_W'(c.ramp_hi_duty));
        put_reg(REG_STALL_CUR,  C_CFG_DAT_W'(c.stall_current_limit));
        put_reg(REG_PRECHARGE,  c.precharge_ticks);
        put_reg(REG_CUR_LOCK,   c.current_lock_ticks);
        put_reg(REG_PHASE_LOCK, c.phase_lock_ticks);
        put_reg(REG_STEP_TICKS, c.start_step_ticks);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic run_phase(input int n, input int stop_pct, input int start_pct,
                             input int ev_pct, input int cur_hi);
        for (int i = 0; i < n; i++) begin
            if (i == n / 2)
                drain();
            send_tick(rand_tick(stop_pct, start_pct, ev_pct, cur_hi));
        end
    endtask

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL hall_bldc_start_run_controller");
        $finish;
    end

    initial begin : stimulus
        t_cfg  c;
        t_item it;
        in_ch.valid             = 1'b0;
        in_ch.command           = CMD_NONE;
        in_ch.hall              = '0;
        in_ch.direction         = 1'b0;
        in_ch.aim_duty          = '0;
        in_ch.current_sample    = '0;
        in_ch.commutation_event = 1'b0;
        cfg_ch.valid            = 1'b0;
        cfg_ch.index            = REG_START_MIN;
        cfg_ch.data             = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        jitter  <= 1'b1;
        @(negedge i_clk);

        // directed: reset registers, precharge entry, ignored commands
        send_tick(tick_item(CMD_NONE,     0, 0, 0,    0,    0));
        send_tick(tick_item(CMD_RESERVED, 7, 1, 2047, 4095, 1));
        send_tick(tick_item(CMD_START,    1, 0, 100,  10,   0));
        send_tick(tick_item(CMD_NONE,     2, 1, 100,  10,   0));
        send_tick(tick_item(CMD_START,    3, 0, 100,  10,   1));
        send_tick(tick_item(CMD_STOP,     4, 1, 100,  10,   0));

        // duty sum carries past 11 bits and saturates
        c.ramp_lo_duty        = 11'd2040;
        c.ramp_inc_duty       = 11'd2047;
        c.ramp_hi_duty        = 11'd2047;
        c.stall_current_limit = 12'd4095;
        c.precharge_ticks     = 16'd1;
        c.current_lock_ticks  = 16'hFFFF;
        c.phase_lock_ticks    = 16'hFFFF;
        c.start_step_ticks    = 16'd2;
        write_config(c);
        send_tick(tick_item(CMD_START,    3, 0, 0,    0,    0));
        send_tick(tick_item(CMD_NONE,     0, 0, 0,    0,    0));
        send_tick(tick_item(CMD_NONE,     0, 0, 0,    0,    0));
        send_tick(tick_item(CMD_NONE,     0, 0, 0,    0,    0));
        send_tick(tick_item(CMD_NONE,     7, 1, 0,    0,    0));
        send_tick(tick_item(CMD_NONE,     5, 1, 0,    0,    0));
        send_tick(tick_item(CMD_NONE,     5, 1, 0,    0,    0));
        send_tick(tick_item(CMD_NONE,     4, 0, 0,    0,    1));
        send_tick(tick_item(CMD_NONE,     6, 0, 0,    0,    1));
        send_tick(tick_item(CMD_NONE,     2, 0, 0,    0,    1));
        send_tick(tick_item(CMD_NONE,     1, 0, 2047, 4095, 0));
        send_tick(tick_item(CMD_NONE,     6, 1, 0,    0,    0));
        send_tick(tick_item(CMD_NONE,     0, 0, 1024, 2048, 0));
        send_tick(tick_item(CMD_RESERVED, 2, 0, 1,    1,    1));
        send_tick(tick_item(CMD_START,    3, 1, 2046, 4094, 0));
        send_tick(tick_item(CMD_STOP,     5, 0, 512,  7,    0));

        write_config(fast_cfg(65535, 65535, 65535, 65535));
        run_phase(400, 2, 10, 30, 4095);

        write_config(fast_cfg(65535, 65535, 65535, 65535));
        jitter <= 1'b0;
        run_phase(400, 1, 8, 45, 4095);
        jitter <= 1'b1;

        c.ramp_lo_duty        = 11'd2047;
        c.ramp_inc_duty       = 11'd2047;
        c.ramp_hi_duty        = 11'd2047;
        c.stall_current_limit = 12'd4095;
        c.precharge_ticks     = 16'hFFFF;
        c.current_lock_ticks  = 16'hFFFF;
        c.phase_lock_ticks    = 16'hFFFF;
        c.start_step_ticks    = 16'hFFFF;
        write_config(c);
        run_phase(60, 0, 20, 30, 4095);

        // run without hall edges: speed timer keeps counting down
        write_config(fast_cfg(65535, 65535, 65535, 65535));
        it = rand_tick(0, 0, 0, 4095);
        it.command = CMD_STOP;
        send_tick(it);
        it.command = CMD_START;
        send_tick(it);
        run_phase(40, 0, 0, 60, 4095);
        run_phase(60, 0, 0, 0, 4095);

        // phase stall only
        write_config(fast_cfg(65535, 65535, 5, 200));
        run_phase(400, 2, 10, 30, 4095);

        // current stall as well
        write_config(fast_cfg(0, 60, 0, 200));
        run_phase(400, 2, 10, 30, 4095);

        write_config('0);
        run_phase(100, 3, 15, 30, 4095);

        write_config(fast_cfg(0, 60, 0, 200));
        jitter <= 1'b0;
        run_phase(300, 2, 10, 30, 4095);

        in_ch.valid <= 1'b0;
        wait (outstanding == 0);
        repeat (4) @(negedge i_clk);
        if (errors == 0)
            $display("PASS hall_bldc_start_run_controller");
        else
            $display("FAIL hall_bldc_start_run_controller");
        $finish;
    end

endmodule
